>>> rtl/nearest_neighbor_scaler_cross_average_assert.svh
// Assertion macros used by the port-level checker of the scaler.
`ifndef NEAREST_NEIGHBOR_SCALER_CROSS_AVERAGE_ASSERT_SVH
`define NEAREST_NEIGHBOR_SCALER_CROSS_AVERAGE_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define NNSCA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define NNSCA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/nnsca_pkg.sv
// Package: constants, codes and types of the nearest neighbor scaler.
`timescale 1ns / 1ps

package nnsca_pkg;

	localparam int MAX_ROWS   = 256;
	localparam int MAX_COLS   = 256;
	localparam int MAX_RADIUS = 16;

	localparam int CH_W    = 8;
	localparam int PIX_W   = 3 * CH_W;
	localparam int ROW_W   = $clog2(MAX_ROWS);
	localparam int COL_W   = $clog2(MAX_COLS);
	localparam int ADDR_W  = $clog2(MAX_ROWS * MAX_COLS);
	localparam int DEPTH   = MAX_ROWS * MAX_COLS;
	localparam int DIM_W   = 16;
	localparam int IN_W    = 8;
	localparam int SIZE_W  = 9;
	localparam int SCALE_W = 24;
	localparam int RADR_W  = 5;
	localparam int PROD_W  = IN_W + SCALE_W;
	localparam int FRAC_W  = 16;
	localparam int I_W     = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS) : 1;
	localparam int K_W     = I_W + 2;
	localparam int CNT_W   = $clog2(4 * MAX_RADIUS + 1);
	localparam int SUM_W   = $clog2(4 * MAX_RADIUS * 255 + 1);
	localparam int STEP_W  = $clog2(SUM_W);

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = SCALE_W;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_SOURCE_ROWS = 3'd0,
		REG_SOURCE_COLS = 3'd1,
		REG_ROW_SCALE   = 3'd2,
		REG_COL_SCALE   = 3'd3,
		REG_INTERPOLATE = 3'd4,
		REG_RADIUS      = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_MAP,
		S_SCAN,
		S_DRAIN,
		S_DIV
	} state_t;

	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_RIGHT = 2'd3
	} dir_t;

endpackage

>>> rtl/nearest_neighbor_scaler_cross_average.sv
// Top level: frame store, nearest neighbor mapping and cross average sequencer.
`timescale 1ns / 1ps

// Usage:
// An item is taken at a clock edge with start high and busy low. opcode selects
// a load (row, col, red, green, blue written to the frame store) or a request
// (row, col name an output pixel). A load gives no result; busy stays low and
// the next item may follow at once.
// A request raises busy. The block multiplies and saturates the coordinates,
// reads the center and its cross neighbors from the frame memory one per cycle,
// then divides the three channel sums bit-serially by the neighbor count.
// The result shows on out_red/out_green/out_blue with done high for one cycle.
// The scan makes 4 * radius reads with averaging on and radius nonzero, else
// one. busy is low in the done cycle, so a new item is accepted at the edge
// that ends it; a new request is not taken before the last result is shown.
// The single read port of the frame memory and the one-bit-per-cycle divider
// set how long a request takes. The receiver cannot stall; each result is
// shown once. cfg_we/cfg_addr/cfg_data write a register. The user must write
// only while idle; the block does not enforce it. Reset clears the sequencer
// and loads register defaults; the frame store is not cleared and must be
// loaded before it is read.

module nearest_neighbor_scaler_cross_average (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                opcode,
	input  logic [7:0]                          row,
	input  logic [7:0]                          col,
	input  logic [7:0]                          red,
	input  logic [7:0]                          green,
	input  logic [7:0]                          blue,
	input  logic                                cfg_we,
	input  logic [nnsca_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [nnsca_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                                done,
	output logic [7:0]                          out_red,
	output logic [7:0]                          out_green,
	output logic [7:0]                          out_blue
);

	import nnsca_pkg::*;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

	state_t state_q, state_d;

	logic [SIZE_W-1:0]  src_rows_q, src_cols_q;
	logic [SCALE_W-1:0] row_scale_q, col_scale_q;
	logic               interp_q;
	logic [RADR_W-1:0]  radius_q;

	logic [IN_W-1:0]   req_row_q, req_col_q;
	logic [PROD_W-1:0] prod_r_q, prod_c_q;
	logic [ROW_W-1:0]  r_q;
	logic [COL_W-1:0]  c_q;
	logic [K_W-1:0]    k_q, k_last_q;
	logic [CNT_W-1:0]  count_q;
	logic [STEP_W-1:0] step_q;
	logic              take_s1;
	logic              done_q;
	logic [SUM_W-1:0]  sum_q [3];
	logic [CNT_W-1:0]  rem_q [3];
	logic [CH_W-1:0]   out_q [3];

	logic [DIM_W-1:0] rows, cols, rad, s_r, s_c, rr, cc, ii, k_last_full;
	logic             avg;
	logic             accept, load_we, scan_en, div_last;
	logic [ROW_W-1:0] nb_r;
	logic [COL_W-1:0] nb_c;
	logic             nb_valid;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [PIX_W-1:0] rdata;
	logic [CNT_W:0]   rem_sh [3];
	logic             qbit [3];
	logic [CNT_W-1:0] rem_nx [3];

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_rows_q  <= SIZE_W'(256);
			src_cols_q  <= SIZE_W'(256);
			row_scale_q <= SCALE_W'(65536);
			col_scale_q <= SCALE_W'(65536);
			interp_q    <= 1'b0;
			radius_q    <= RADR_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_SOURCE_ROWS: src_rows_q  <= cfg_data[SIZE_W-1:0];
				REG_SOURCE_COLS: src_cols_q  <= cfg_data[SIZE_W-1:0];
				REG_ROW_SCALE:   row_scale_q <= cfg_data[SCALE_W-1:0];
				REG_COL_SCALE:   col_scale_q <= cfg_data[SCALE_W-1:0];
				REG_INTERPOLATE: interp_q    <= cfg_data[0];
				REG_RADIUS:      radius_q    <= cfg_data[RADR_W-1:0];
				default: ;
			endcase
		end
	end

	// effective sizes and radius
	always_comb begin
		if (src_rows_q == '0) begin
			rows = DIM_W'(1);
		end else if (DIM_W'(src_rows_q) > DIM_W'(MAX_ROWS)) begin
			rows = DIM_W'(MAX_ROWS);
		end else begin
			rows = DIM_W'(src_rows_q);
		end
		if (src_cols_q == '0) begin
			cols = DIM_W'(1);
		end else if (DIM_W'(src_cols_q) > DIM_W'(MAX_COLS)) begin
			cols = DIM_W'(MAX_COLS);
		end else begin
			cols = DIM_W'(src_cols_q);
		end
		rad = (DIM_W'(radius_q) > DIM_W'(MAX_RADIUS)) ? DIM_W'(MAX_RADIUS) :
			DIM_W'(radius_q);
		avg = interp_q && (rad != '0);
		k_last_full = (rad << 2) - DIM_W'(1);
		s_r = prod_r_q[FRAC_W +: DIM_W];
		s_c = prod_c_q[FRAC_W +: DIM_W];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start && opcode == OP_REQUEST) begin
					state_d = S_MUL;
				end
			end
			S_MUL:   state_d = S_MAP;
			S_MAP:   state_d = S_SCAN;
			S_SCAN: begin
				if (k_q == k_last_q) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: state_d = S_DIV;
			S_DIV: begin
				if (step_q == STEP_LAST) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		busy     = (state_q != S_IDLE);
		accept   = start && (state_q == S_IDLE);
		load_we  = accept && (opcode == OP_LOAD) &&
			(DIM_W'(row) < DIM_W'(MAX_ROWS)) && (DIM_W'(col) < DIM_W'(MAX_COLS));
		scan_en  = (state_q == S_SCAN);
		div_last = (state_q == S_DIV) && (step_q == STEP_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// neighbor address for the current scan step
	always_comb begin
		rr = DIM_W'(r_q);
		cc = DIM_W'(c_q);
		ii = DIM_W'(k_q[K_W-1:2]);
		nb_r = r_q;
		nb_c = c_q;
		nb_valid = 1'b0;
		unique case (dir_t'(k_q[1:0]))
			DIR_UP: begin
				nb_valid = (ii <= rr);
				nb_r = ROW_W'(rr - ii);
			end
			DIR_DOWN: begin
				nb_valid = ((rr + ii) < rows);
				nb_r = ROW_W'(rr + ii);
			end
			DIR_LEFT: begin
				nb_valid = (ii <= cc);
				nb_c = COL_W'(cc - ii);
			end
			DIR_RIGHT: begin
				nb_valid = ((cc + ii) < cols);
				nb_c = COL_W'(cc + ii);
			end
			default: ;
		endcase
		raddr = ADDR_W'(ADDR_W'(nb_r) * ADDR_W'(MAX_COLS)) + ADDR_W'(nb_c);
		waddr = ADDR_W'(ADDR_W'(ROW_W'(row)) * ADDR_W'(MAX_COLS)) + ADDR_W'(COL_W'(col));
	end

	nnsca_ram #(
		.WIDTH(PIX_W),
		.DEPTH(DEPTH)
	) u_frame (
		.clk   (clk),
		.we    (load_we),
		.waddr (waddr),
		.wdata ({red, green, blue}),
		.raddr (raddr),
		.rdata (rdata)
	);

	// restoring divider step, one quotient bit per channel per cycle
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			rem_sh[ch] = {rem_q[ch], sum_q[ch][SUM_W-1]};
			qbit[ch]   = (rem_sh[ch] >= {1'b0, count_q});
			rem_nx[ch] = qbit[ch] ? CNT_W'(rem_sh[ch] - {1'b0, count_q}) :
				CNT_W'(rem_sh[ch]);
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			k_last_q <= '0;
			count_q  <= '0;
			step_q   <= '0;
			take_s1  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			take_s1 <= scan_en && nb_valid;
			done_q  <= div_last;
			if (state_q == S_MAP) begin
				k_q      <= '0;
				k_last_q <= avg ? K_W'(k_last_full) : '0;
				count_q  <= '0;
				step_q   <= '0;
			end else if (scan_en) begin
				k_q <= k_q + K_W'(1);
				if (nb_valid) begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (state_q == S_DIV) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			req_row_q <= row;
			req_col_q <= col;
		end
		if (state_q == S_MUL) begin
			prod_r_q <= PROD_W'(req_row_q) * PROD_W'(row_scale_q);
			prod_c_q <= PROD_W'(req_col_q) * PROD_W'(col_scale_q);
		end
		if (state_q == S_MAP) begin
			r_q <= ROW_W'((s_r >= rows) ? rows - DIM_W'(1) : s_r);
			c_q <= COL_W'((s_c >= cols) ? cols - DIM_W'(1) : s_c);
		end
		for (int ch = 0; ch < 3; ch++) begin
			priority if (state_q == S_MAP) begin
				sum_q[ch] <= '0;
				rem_q[ch] <= '0;
			end else if (state_q == S_DIV) begin
				sum_q[ch] <= {sum_q[ch][SUM_W-2:0], qbit[ch]};
				rem_q[ch] <= rem_nx[ch];
			end else if (take_s1) begin
				sum_q[ch] <= sum_q[ch] + SUM_W'(rdata[PIX_W-1-CH_W*ch -: CH_W]);
			end
			if (div_last) begin
				out_q[ch] <= {sum_q[ch][CH_W-2:0], qbit[ch]};
			end
		end
	end

	assign done      = done_q;
	assign out_red   = out_q[0];
	assign out_green = out_q[1];
	assign out_blue  = out_q[2];

endmodule

>>> rtl/nnsca_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module nnsca_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/nnsca_checker.sv
// Port-level checker for the scaler, bound to the top level.
`timescale 1ns / 1ps
`include "nearest_neighbor_scaler_cross_average_assert.svh"

module nnsca_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic opcode,
	input logic done
);

	import nnsca_pkg::*;

	`NNSCA_ASSERT(a_done_ends_busy, done |-> $past(busy), "result without a request in flight")
	`NNSCA_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
	`NNSCA_ASSERT_NEXT(a_req_busy, start && !busy && opcode == OP_REQUEST, busy, "request did not raise busy")
	`NNSCA_ASSERT_NEXT(a_load_quiet, start && !busy && opcode == OP_LOAD, !busy && !done, "load item caused work or a result")

endmodule

bind nearest_neighbor_scaler_cross_average nnsca_checker u_nnsca_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.opcode (opcode),
	.done   (done)
);

>>> dv/nearest_neighbor_scaler_cross_average_checker.sv
// Checker: mirrors registers and frame store, predicts each requested pixel, compares results.
`timescale 1ns / 1ps

module nearest_neighbor_scaler_cross_average_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  logic                             opcode,
	input  logic [7:0]                       row,
	input  logic [7:0]                       col,
	input  logic [7:0]                       red,
	input  logic [7:0]                       green,
	input  logic [7:0]                       blue,
	input  logic                             cfg_we,
	input  logic [nnsca_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [nnsca_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             done,
	input  logic [7:0]                       out_red,
	input  logic [7:0]                       out_green,
	input  logic [7:0]                       out_blue,
	output int                               mismatch_count,
	output int                               pending_count
);
	import nnsca_pkg::*;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	logic [PIX_W-1:0]   pixel_mem [0:DEPTH-1];
	logic [SIZE_W-1:0]  rows_q;
	logic [SIZE_W-1:0]  cols_q;
	logic [SCALE_W-1:0] row_scale_q;
	logic [SCALE_W-1:0] col_scale_q;
	logic               interp_q;
	logic [RADR_W-1:0]  radius_q;

	rgb_t pending_pixels [$];
	int   fail_total;

	function automatic logic [PIX_W-1:0] stored(input int unsigned r, input int unsigned c);
		return pixel_mem[r * MAX_COLS + c];
	endfunction

	function automatic int unsigned fit_size(input logic [SIZE_W-1:0] v, input int unsigned lim);
		if (v == 0)
			return 1;
		return (v > lim) ? lim : v;
	endfunction

	function automatic int unsigned map_coord(input logic [7:0] pos, input logic [SCALE_W-1:0] scale,
			input int unsigned size);
		logic [PROD_W-1:0] prod;
		prod = pos * scale;
		prod = prod >> FRAC_W;
		return (prod >= size) ? size - 1 : prod;
	endfunction

	function automatic rgb_t predict_pixel(input logic [7:0] orow, input logic [7:0] ocol);
		int unsigned nrows, ncols, sr, sc, nrad, cnt, tr, tc;
		int unsigned acc_r, acc_g, acc_b;
		logic [PIX_W-1:0] px;
		logic ok;
		rgb_t res;
		nrows = fit_size(rows_q, MAX_ROWS);
		ncols = fit_size(cols_q, MAX_COLS);
		sr = map_coord(orow, row_scale_q, nrows);
		sc = map_coord(ocol, col_scale_q, ncols);
		px = stored(sr, sc);
		nrad = (radius_q > MAX_RADIUS) ? MAX_RADIUS : radius_q;
		if (interp_q && nrad != 0) begin
			acc_r = 0;
			acc_g = 0;
			acc_b = 0;
			cnt = 0;
			for (int unsigned i = 0; i < nrad; i++) begin
				for (int d = 0; d < 4; d++) begin
					tr = sr;
					tc = sc;
					case (dir_t'(d))
						DIR_UP: begin
							ok = (i <= sr);
							tr = sr - i;
						end
						DIR_DOWN: begin
							ok = (sr + i < nrows);
							tr = sr + i;
						end
						DIR_LEFT: begin
							ok = (i <= sc);
							tc = sc - i;
						end
						default: begin
							ok = (sc + i < ncols);
							tc = sc + i;
						end
					endcase
					if (ok) begin
						px = stored(tr, tc);
						acc_r += px[23:16];
						acc_g += px[15:8];
						acc_b += px[7:0];
						cnt++;
					end
				end
			end
			px = {8'(acc_r / cnt), 8'(acc_g / cnt), 8'(acc_b / cnt)};
		end
		res.r = px[23:16];
		res.g = px[15:8];
		res.b = px[7:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rgb_t want;
		if (!arst_n) begin
			rows_q <= SIZE_W'(MAX_ROWS);
			cols_q <= SIZE_W'(MAX_COLS);
			row_scale_q <= SCALE_W'(1 << FRAC_W);
			col_scale_q <= SCALE_W'(1 << FRAC_W);
			interp_q <= 1'b0;
			radius_q <= RADR_W'(1);
			pending_pixels.delete();
			fail_total = 0;
			mismatch_count <= 0;
			pending_count <= 0;
		end else begin
			if (done) begin
				if (pending_pixels.size() == 0) begin
					$error("result with no pending request: %0d %0d %0d",
						out_red, out_green, out_blue);
					fail_total++;
				end else begin
					want = pending_pixels.pop_front();
					if (out_red !== want.r) begin
						$error("out_red: expected %0d, actual %0d", want.r, out_red);
						fail_total++;
					end
					if (out_green !== want.g) begin
						$error("out_green: expected %0d, actual %0d", want.g, out_green);
						fail_total++;
					end
					if (out_blue !== want.b) begin
						$error("out_blue: expected %0d, actual %0d", want.b, out_blue);
						fail_total++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_addr))
					REG_SOURCE_ROWS: rows_q <= cfg_data[SIZE_W-1:0];
					REG_SOURCE_COLS: cols_q <= cfg_data[SIZE_W-1:0];
					REG_ROW_SCALE:   row_scale_q <= cfg_data[SCALE_W-1:0];
					REG_COL_SCALE:   col_scale_q <= cfg_data[SCALE_W-1:0];
					REG_INTERPOLATE: interp_q <= cfg_data[0];
					REG_RADIUS:      radius_q <= cfg_data[RADR_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (opcode == OP_LOAD)
					pixel_mem[{row, col}] <= {red, green, blue};
				else
					pending_pixels.push_back(predict_pixel(row, col));
			end
			mismatch_count <= fail_total;
			pending_count <= pending_pixels.size();
		end
	end

endmodule

>>> dv/nearest_neighbor_scaler_cross_average_tb.sv
// Testbench top: clock, reset, load and request stimulus, and the final verdict.
`timescale 1ns / 1ps

module nearest_neighbor_scaler_cross_average_tb;
	import nnsca_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 1700;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  opcode = OP_LOAD;
	logic [7:0]            row = '0;
	logic [7:0]            col = '0;
	logic [7:0]            red = '0;
	logic [7:0]            green = '0;
	logic [7:0]            blue = '0;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  busy;
	logic                  done;
	logic [7:0]            out_red;
	logic [7:0]            out_green;
	logic [7:0]            out_blue;
	int                    mismatch_count;
	int                    pending_count;

	bit          loaded [0:DEPTH-1];
	int          item_total = 0;
	bit          idle_en = 1'b1;
	int unsigned cycle_count = 0;

	always #6 clk = ~clk;

	nearest_neighbor_scaler_cross_average DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
		.row(row), .col(col), .red(red), .green(green), .blue(blue),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.done(done), .out_red(out_red), .out_green(out_green), .out_blue(out_blue)
	);

	nearest_neighbor_scaler_cross_average_checker pixel_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
		.row(row), .col(col), .red(red), .green(green), .blue(blue),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.done(done), .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
		.mismatch_count(mismatch_count), .pending_count(pending_count)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] rand_coord();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic int eff_size(input logic [SIZE_W-1:0] v, input int lim);
		if (v == 0)
			return 1;
		return (v > lim) ? lim : v;
	endfunction

	task automatic maybe_idle();
		int n;
		if (idle_en && $urandom_range(3) == 0) begin
			n = $urandom_range(10, 1);
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_item(input logic op, input logic [7:0] r, input logic [7:0] c,
			input logic [7:0] rv, input logic [7:0] gv, input logic [7:0] bv);
		maybe_idle();
		start <= 1'b1;
		opcode <= op;
		row <= r;
		col <= c;
		red <= rv;
		green <= gv;
		blue <= bv;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		item_total++;
		if (op == OP_LOAD)
			loaded[{r, c}] = 1'b1;
	endtask

	// block idle, all results in, trailing load finished
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_count != 0 || busy)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic run_phase(input logic [SIZE_W-1:0] rows_v, input logic [SIZE_W-1:0] cols_v,
			input logic [SCALE_W-1:0] rs, input logic [SCALE_W-1:0] cs,
			input logic ip, input logic [RADR_W-1:0] rad, input int n_req);
		int nr, nc, sent;
		logic [31:0] junk;
		settle();
		junk = $urandom;
		write_reg(REG_SOURCE_ROWS, {junk[14:0], rows_v});
		write_reg(REG_SOURCE_COLS, {junk[29:15], cols_v});
		write_reg(REG_ROW_SCALE, rs);
		write_reg(REG_COL_SCALE, cs);
		write_reg(REG_INTERPOLATE, {junk[22:0], ip});
		write_reg(REG_RADIUS, {junk[31:13], rad});
		cfg_we <= 1'b0;
		nr = eff_size(rows_v, MAX_ROWS);
		nc = eff_size(cols_v, MAX_COLS);
		// every pixel a request can reach must be written first
		for (int r = 0; r < nr; r++)
			for (int c = 0; c < nc; c++)
				if (!loaded[r * MAX_COLS + c])
					send_item(OP_LOAD, 8'(r), 8'(c), rand_chan(), rand_chan(), rand_chan());
		send_item(OP_REQUEST, 8'h00, 8'h00, rand_chan(), rand_chan(), rand_chan());
		send_item(OP_REQUEST, 8'hFF, 8'hFF, rand_chan(), rand_chan(), rand_chan());
		send_item(OP_REQUEST, 8'h00, 8'hFF, rand_chan(), rand_chan(), rand_chan());
		send_item(OP_REQUEST, 8'hFF, 8'h00, rand_chan(), rand_chan(), rand_chan());
		sent = 4;
		while (sent < n_req) begin
			if ($urandom_range(4) == 0) begin
				send_item(OP_LOAD, 8'($urandom), 8'($urandom), rand_chan(), rand_chan(),
					rand_chan());
			end else begin
				send_item(OP_REQUEST, rand_coord(), rand_coord(), rand_chan(), rand_chan(),
					rand_chan());
				sent++;
			end
		end
	endtask

	initial begin
		int base, nr, nc, big;
		logic [SIZE_W-1:0] rows_v, cols_v;
		logic [SCALE_W-1:0] rs, cs;
		logic ip;
		logic [RADR_W-1:0] rad;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: plain nearest, radius zero, edge clipping, clamped registers
		run_phase(9'd4, 9'd4, 24'd65536, 24'd65536, 1'b0, 5'd1, 4);
		run_phase(9'd4, 9'd4, 24'd65536, 24'd65536, 1'b1, 5'd0, 4);
		run_phase(9'd5, 9'd3, 24'd65536, 24'd65536, 1'b1, 5'd3, 5);
		run_phase(9'd0, 9'd6, 24'hFFFFFF, 24'd0, 1'b1, 5'd31, 4);
		run_phase(9'd3, 9'd3, 24'd16384, 24'd196608, 1'b1, 5'd16, 4);

		base = item_total;
		run_phase(9'd511, 9'd1, 24'd65536, 24'd32768, 1'b1, 5'd16, 20);
		run_phase(9'd1, 9'd300, 24'd0, 24'd65536, 1'b1, 5'd16, 20);
		while (item_total < base + RANDOM_ITEMS) begin
			if (item_total > base + RANDOM_ITEMS * 4 / 5)
				idle_en = 1'b0;
			rows_v = 9'($urandom_range(16, 1));
			cols_v = 9'($urandom_range(16, 1));
			big = $urandom_range(19);
			if (big == 0)
				rows_v = 9'd0;
			else if (big == 1)
				cols_v = 9'd0;
			else if (big == 2) begin
				rows_v = 9'($urandom_range(511, 200));
				cols_v = 9'($urandom_range(4, 1));
			end else if (big == 3) begin
				cols_v = 9'($urandom_range(511, 200));
				rows_v = 9'($urandom_range(4, 1));
			end
			nr = eff_size(rows_v, MAX_ROWS);
			nc = eff_size(cols_v, MAX_COLS);
			case ($urandom_range(4))
				0: begin
					rs = 24'd65536;
					cs = 24'd65536;
				end
				1: begin
					rs = 24'(nr * 256);
					cs = 24'(nc * 256);
				end
				2: begin
					rs = 24'($urandom);
					cs = 24'($urandom);
				end
				3: begin
					rs = 24'($urandom_range(131072));
					cs = 24'($urandom_range(131072));
				end
				default: begin
					rs = $urandom_range(1) ? 24'hFFFFFF : 24'd0;
					cs = $urandom_range(1) ? 24'hFFFFFF : 24'd0;
				end
			endcase
			ip = ($urandom_range(3) != 0);
			rad = ($urandom_range(5) == 0) ? 5'($urandom_range(31, 17)) : 5'($urandom_range(16));
			run_phase(rows_v, cols_v, rs, cs, ip, rad, $urandom_range(60, 15));
		end

		settle();
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/nnsca_pkg.sv
rtl/nnsca_ram.sv
rtl/nearest_neighbor_scaler_cross_average.sv
rtl/nnsca_checker.sv
dv/nearest_neighbor_scaler_cross_average_checker.sv
dv/nearest_neighbor_scaler_cross_average_tb.sv
